// ----- hw/rtl/rgb_threshold_bit_packer_assert.svh -----
// Assertion macros shared by the threshold packer RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef RGB_THRESHOLD_BIT_PACKER_ASSERT_SVH
`define RGB_THRESHOLD_BIT_PACKER_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define RTBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rtbp assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define RTBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rtbp assertion failed");

`endif

// ----- hw/rtl/rtbp_pkg.sv -----
// Shared types and constants of the threshold packer.
// Depends on nothing; used by every module of the block.
package rtbp_pkg;

  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int SIZE_W = 13;
  localparam int THR_W  = 8;
  localparam int PIX_W  = 8;
  localparam int LUMA_W = 18;

  localparam logic [LUMA_W-1:0] COEF_R     = LUMA_W'(299);
  localparam logic [LUMA_W-1:0] COEF_G     = LUMA_W'(587);
  localparam logic [LUMA_W-1:0] COEF_B     = LUMA_W'(114);
  localparam logic [LUMA_W-1:0] LUMA_SCALE = LUMA_W'(1000);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_LUMA_THRESHOLD = 3'd2,
    CFG_PAD_ROWS       = 3'd3,
    CFG_REVERSE_BITS   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [THR_W-1:0]  luma_threshold;
    logic              pad_rows;
    logic              reverse_bits;
  } cfg_t;

  typedef struct packed {
    logic pix_bit;
    logic row_end;
    logic frame_end;
  } q_entry_t;

endpackage

// ----- hw/rtl/rgb_threshold_bit_packer.sv -----
// RGB to 1-bit-per-pixel threshold packer, top level.
// Accepts one pixel a cycle on in_* unless stalled, emits packed bytes on out_*, config on cfg_*.
// Depends on rtbp_pkg, rtbp_front, rtbp_queue and rtbp_back.
//
// Pixels arrive in row-major order on in_red/in_green/in_blue; a transaction
// completes when in_valid is high and in_stall is low. Each pixel is thresholded
// on 299r+587g+114b and packed MSB-first (LSB-first if reverse_bits); a byte leaves on
// out_packed_byte when eight bits are full, at row end when pad_rows is set, and at
// frame end, where out_frame_last marks it. A result transaction completes on
// out_valid && !out_stall. Throughput is one pixel per cycle while in_stall is low;
// the front end's column/row counter and the back end's bit accumulator update once
// per pixel taken. A byte passes through the queue and then the output register, and
// its result transaction completes once it shows there and out_stall is low.
// When out_stall holds a byte, the back end keeps draining pixels that emit nothing,
// and a four-entry queue absorbs up to four more; in_stall rises only when it is full.
// Registers are written through cfg_index/cfg_data with cfg_valid (cfg_ready is
// always high); the user must write them only while idle, which the block does not
// enforce; unknown indexes are dropped. Synchronous reset restores the default
// registers (128x64, threshold 128) and clears counters, accumulator, queue, out_valid.
module rgb_threshold_bit_packer #(
  parameter int MAX_WIDTH   = rtbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = rtbp_pkg::MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = rtbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rtbp_pkg::PIX_W-1:0]       in_red,
  input  logic [rtbp_pkg::PIX_W-1:0]       in_green,
  input  logic [rtbp_pkg::PIX_W-1:0]       in_blue,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_packed_byte,
  output logic                             out_frame_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rtbp_pkg::cfg_t     cfg_r, cfg_nxt;
  rtbp_pkg::q_entry_t push_entry;
  rtbp_pkg::q_entry_t q_entry;
  logic               push;
  logic               pop;
  logic               q_valid;
  logic               q_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (rtbp_pkg::cfg_idx_t'(cfg_index))
        rtbp_pkg::CFG_FRAME_WIDTH:    cfg_nxt.frame_width    = cfg_data;
        rtbp_pkg::CFG_FRAME_HEIGHT:   cfg_nxt.frame_height   = cfg_data;
        rtbp_pkg::CFG_LUMA_THRESHOLD: cfg_nxt.luma_threshold = cfg_data[rtbp_pkg::THR_W-1:0];
        rtbp_pkg::CFG_PAD_ROWS:       cfg_nxt.pad_rows       = cfg_data[0];
        rtbp_pkg::CFG_REVERSE_BITS:   cfg_nxt.reverse_bits   = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= rtbp_pkg::SIZE_W'(128);
      cfg_r.frame_height   <= rtbp_pkg::SIZE_W'(64);
      cfg_r.luma_threshold <= rtbp_pkg::THR_W'(128);
      cfg_r.pad_rows       <= 1'b0;
      cfg_r.reverse_bits   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rtbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .push       (push),
    .push_entry (push_entry)
  );

  rtbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .full       (q_full)
  );

  rtbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_byte (out_packed_byte),
    .out_frame_last  (out_frame_last)
  );

endmodule

// ----- hw/rtl/rtbp_front.sv -----
// Front end: accepts pixels, thresholds luma and tracks column and row position.
// Depends on rtbp_pkg and the assertion header.
`include "rgb_threshold_bit_packer_assert.svh"
module rtbp_front #(
  parameter int MAX_WIDTH  = rtbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rtbp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rtbp_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [rtbp_pkg::PIX_W-1:0]  in_red,
  input  logic [rtbp_pkg::PIX_W-1:0]  in_green,
  input  logic [rtbp_pkg::PIX_W-1:0]  in_blue,
  output logic                        push,
  output rtbp_pkg::q_entry_t          push_entry
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int LW = rtbp_pkg::LUMA_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] width_c;
  logic [HW-1:0] height_c;
  logic [WW:0]   col_plus;
  logic [HW:0]   row_plus;
  logic [LW-1:0] luma_sum;
  logic [LW-1:0] luma_limit;
  logic          row_end;
  logic          frame_end;

  always_comb begin
    if (cfg.frame_width == '0) begin
      width_c = WW'(1);
    end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
      width_c = WW'(MAX_WIDTH);
    end else begin
      width_c = WW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      height_c = HW'(1);
    end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
      height_c = HW'(MAX_HEIGHT);
    end else begin
      height_c = HW'(cfg.frame_height);
    end
  end

  assign col_plus  = (WW+1)'(col_r) + (WW+1)'(1);
  assign row_plus  = (HW+1)'(row_r) + (HW+1)'(1);
  assign row_end   = col_plus >= (WW+1)'(width_c);
  assign frame_end = row_end && (row_plus >= (HW+1)'(height_c));

  assign luma_sum = LW'(in_red) * rtbp_pkg::COEF_R + LW'(in_green) * rtbp_pkg::COEF_G
                  + LW'(in_blue) * rtbp_pkg::COEF_B;
  assign luma_limit = (LW'(cfg.luma_threshold) + LW'(1)) * rtbp_pkg::LUMA_SCALE;

  assign push                 = in_valid && !in_stall;
  assign push_entry.pix_bit   = luma_sum >= luma_limit;
  assign push_entry.row_end   = row_end;
  assign push_entry.frame_end = frame_end;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : RW'(row_plus);
      end else begin
        col_nxt = CW'(col_plus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `RTBP_ASSERT_NEXT(a_col_wrap, clk, rst_n, push && row_end, col_r == '0)
  `RTBP_ASSERT_NEXT(a_row_wrap, clk, rst_n, push && frame_end, row_r == '0)
  `RTBP_ASSERT_NEXT(a_hold_idle, clk, rst_n, !push, $stable(col_r) && $stable(row_r))

endmodule

// ----- hw/rtl/rtbp_queue.sv -----
// Short FIFO of classified pixels between front and back end.
// Depends on rtbp_pkg and the assertion header.
`include "rgb_threshold_bit_packer_assert.svh"
module rtbp_queue #(
  parameter int DEPTH = rtbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rtbp_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               q_valid,
  output rtbp_pkg::q_entry_t q_entry,
  output logic               full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  rtbp_pkg::q_entry_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_valid = count_r != '0;
  assign full    = count_r == NW'(DEPTH);
  assign q_entry = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  `RTBP_ASSERT_NOW(a_no_overflow, clk, rst_n, 1'b1, count_r <= NW'(DEPTH))
  `RTBP_ASSERT_NEXT(a_fill, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + NW'(1))
  `RTBP_ASSERT_NEXT(a_drain, clk, rst_n, do_pop && !do_push, count_r == $past(count_r) - NW'(1))

endmodule

// ----- hw/rtl/rtbp_back.sv -----
// Back end: packs classified bits into bytes and holds the output register.
// Depends on rtbp_pkg and the assertion header.
`include "rgb_threshold_bit_packer_assert.svh"
module rtbp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rtbp_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  rtbp_pkg::q_entry_t q_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_packed_byte,
  output logic               out_frame_last
);

  logic [7:0] acc_r, acc_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic [7:0] acc_set;
  logic [7:0] acc_rev;
  logic       emit;
  logic       slot_free;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      acc_rev[i] = acc_set[7-i];
    end
  end

  assign acc_set   = acc_r | (8'(q_entry.pix_bit) << pos_r);
  assign emit      = (pos_r == 3'd0) || q_entry.frame_end || (q_entry.row_end && cfg.pad_rows);
  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = q_valid && (!emit || slot_free);

  always_comb begin
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    if (pop) begin
      if (emit) begin
        acc_nxt       = '0;
        pos_nxt       = 3'd7;
        out_valid_nxt = 1'b1;
        byte_nxt      = cfg.reverse_bits ? acc_rev : acc_set;
        last_nxt      = q_entry.frame_end;
      end else begin
        acc_nxt = acc_set;
        pos_nxt = pos_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pos_r       <= 3'd7;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_packed_byte = byte_r;
  assign out_frame_last  = last_r;

  `RTBP_ASSERT_NEXT(a_emit_clears, clk, rst_n, pop && emit, acc_r == '0 && pos_r == 3'd7)
  `RTBP_ASSERT_NEXT(a_emit_shows, clk, rst_n, pop && emit, out_valid_r)
  `RTBP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(byte_r))

endmodule
